// ----- sv/tlc_pkg.sv -----
// Shared constants and the queued item type of the two-way cache.
`default_nettype none
package tlc_pkg;

  localparam int unsigned SET_COUNT    = 8;
  localparam int unsigned MEMORY_WORDS = 128;
  localparam int unsigned ADDR_W       = 7;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned SET_W        = $clog2(SET_COUNT);
  localparam int unsigned TAG_W        = ADDR_W - SET_W;
  localparam int unsigned MEM_IDX_W    = $clog2(MEMORY_WORDS);
  localparam int unsigned RESET_OFFSET = 5;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [SET_W-1:0]     set_idx;
    logic [TAG_W-1:0]     tag;
    logic [MEM_IDX_W-1:0] mem_idx;
    logic [WORD_W-1:0]    data;
  } item_t;

endpackage
`default_nettype wire

// ----- sv/tlc_front.sv -----
// Front end: accepts requests, splits the address and queues them for the back end.
`default_nettype none
module tlc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [tlc_pkg::ADDR_W-1:0]  word_address_i,
  input  wire logic [tlc_pkg::WORD_W-1:0]  store_data_i,
  output logic                             head_valid_o,
  output tlc_pkg::item_t                   head_o,
  input  wire logic                        pop_i
);
  import tlc_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  item_t             new_item;
  logic              push;

  always_comb begin
    new_item.op      = operation_i;
    new_item.set_idx = word_address_i[SET_W-1:0];
    new_item.tag     = word_address_i[ADDR_W-1:SET_W];
    new_item.mem_idx = MEM_IDX_W'(word_address_i);
    new_item.data    = store_data_i;
  end

  assign in_stall_o   = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tlc_back.sv -----
// Back end: cache arrays, backing memory and the two-phase lookup and update sequencer.
`default_nettype none
module tlc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        head_valid_i,
  input  wire tlc_pkg::item_t              head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             hit_o,
  output logic [tlc_pkg::WORD_W-1:0]       load_data_o
);
  import tlc_pkg::*;

  localparam logic PH_LOOKUP = 1'b0;
  localparam logic PH_UPDATE = 1'b1;

  logic                  phase_q, phase_d;
  logic [SET_COUNT-1:0]  v0_q, v1_q, recent_q;
  logic [TAG_W-1:0]      tag0_q [SET_COUNT];
  logic [TAG_W-1:0]      tag1_q [SET_COUNT];
  logic [WORD_W-1:0]     word0_q [SET_COUNT];
  logic [WORD_W-1:0]     word1_q [SET_COUNT];
  logic [WORD_W-1:0]     mem_q [MEMORY_WORDS];
  logic [MEMORY_WORDS-1:0] mem_vld_q;
  logic [WORD_W-1:0]     rd_data_q;
  logic                  rd_vld_q;
  logic                  out_valid_q, out_valid_d;
  logic                  hit_q;
  logic [WORD_W-1:0]     load_data_q;

  logic                  lookup;
  logic                  commit;
  logic                  is_store;
  logic                  hit0, hit1;
  logic                  victim;
  logic [WORD_W-1:0]     mem_word;
  logic [WORD_W-1:0]     result;

  assign lookup   = (phase_q == PH_LOOKUP) && head_valid_i;
  assign commit   = (phase_q == PH_UPDATE) && (!out_valid_q || !out_stall_i);
  assign pop_o    = commit;
  assign is_store = (head_i.op == OP_STORE);

  always_comb begin
    hit0 = v0_q[head_i.set_idx] && (tag0_q[head_i.set_idx] == head_i.tag);
    hit1 = !hit0 && v1_q[head_i.set_idx] && (tag1_q[head_i.set_idx] == head_i.tag);
    if (!v0_q[head_i.set_idx]) begin
      victim = 1'b0;
    end else if (!v1_q[head_i.set_idx]) begin
      victim = 1'b1;
    end else begin
      victim = !recent_q[head_i.set_idx];
    end
    mem_word = rd_vld_q ? rd_data_q
                        : WORD_W'(head_i.mem_idx) + WORD_W'(RESET_OFFSET);
    if (is_store) begin
      result = '0;
    end else if (hit0) begin
      result = word0_q[head_i.set_idx];
    end else if (hit1) begin
      result = word1_q[head_i.set_idx];
    end else begin
      result = mem_word;
    end
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_LOOKUP: if (lookup) phase_d = PH_UPDATE;
      PH_UPDATE: if (commit) phase_d = PH_LOOKUP;
      default:   phase_d = PH_LOOKUP;
    endcase
    out_valid_d = commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LOOKUP;
      out_valid_q <= 1'b0;
      v0_q        <= '0;
      v1_q        <= '0;
      recent_q    <= '0;
      mem_vld_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        if (is_store) begin
          mem_vld_q[head_i.mem_idx] <= 1'b1;
          if (hit0) begin
            recent_q[head_i.set_idx] <= 1'b0;
          end else if (hit1) begin
            recent_q[head_i.set_idx] <= 1'b1;
          end
        end else if (hit0) begin
          recent_q[head_i.set_idx] <= 1'b0;
        end else if (hit1) begin
          recent_q[head_i.set_idx] <= 1'b1;
        end else begin
          recent_q[head_i.set_idx] <= victim;
          if (victim) begin
            v1_q[head_i.set_idx] <= 1'b1;
          end else begin
            v0_q[head_i.set_idx] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup) begin
      rd_data_q <= mem_q[head_i.mem_idx];
      rd_vld_q  <= mem_vld_q[head_i.mem_idx];
    end
    if (commit && is_store) begin
      mem_q[head_i.mem_idx] <= head_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q       <= hit0 || hit1;
      load_data_q <= result;
      if (is_store) begin
        if (hit0) begin
          word0_q[head_i.set_idx] <= head_i.data;
        end else if (hit1) begin
          word1_q[head_i.set_idx] <= head_i.data;
        end
      end else if (!hit0 && !hit1) begin
        if (victim) begin
          tag1_q[head_i.set_idx]  <= head_i.tag;
          word1_q[head_i.set_idx] <= mem_word;
        end else begin
          tag0_q[head_i.set_idx]  <= head_i.tag;
          word0_q[head_i.set_idx] <= mem_word;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign load_data_o = load_data_q;

endmodule
`default_nettype wire

// ----- sv/two_way_lru_cache_with_memory_core.sv -----
// Top level of the two-way set-associative LRU cache with its backing memory.
`default_nettype none
// Each transfer is a load or a store of one 32-bit word at a 7-bit word address; every
// request yields exactly one result carrying the hit flag and, for loads, the word read
// (stores return zero). Eight sets of two ways sit in front of a 128-word memory whose
// words start out as their address plus five; stores write through without allocating,
// load misses fill the invalid or least recently used way. A two-entry request queue
// decouples the input from the back end, which handles one request at a time in two
// phases: a lookup that reads the backing memory port, then an update of the line, the
// recency bit and the memory, which waits while a held result is stalled at the output.
module two_way_lru_cache_with_memory_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [tlc_pkg::ADDR_W-1:0]  word_address_i,
  input  wire logic [tlc_pkg::WORD_W-1:0]  store_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             hit_o,
  output logic [tlc_pkg::WORD_W-1:0]       load_data_o
);
  import tlc_pkg::*;

  logic  q_head_valid;
  item_t q_head;
  logic  q_pop;

  tlc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .word_address_i (word_address_i),
    .store_data_i   (store_data_i),
    .head_valid_o   (q_head_valid),
    .head_o         (q_head),
    .pop_i          (q_pop)
  );

  tlc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .load_data_o  (load_data_o)
  );

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("Request queue popped while empty.");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("Completed request did not present a result.");

  a_store_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && (q_head.op == OP_STORE)) |=> (load_data_o == '0))
    else $error("Store result carries nonzero load data.");

  a_stall_means_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_head_valid)
    else $error("Input stalled with an empty request queue.");

endmodule
`default_nettype wire

// ----- sim/cache_response_checker.sv -----
// Predicts and checks every transfer of the two-way LRU cache from its ports.
`timescale 1ns / 100ps
module cache_response_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire logic                       operation_i,
  input  wire logic [tlc_pkg::ADDR_W-1:0] word_address_i,
  input  wire logic [tlc_pkg::WORD_W-1:0] store_data_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire logic                       hit_i,
  input  wire logic [tlc_pkg::WORD_W-1:0] load_data_i,
  output int                              pending_o,
  output int                              fail_count_o
);
  import tlc_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] load_data;
  } cache_response_t;

  logic              line_valid [2][SET_COUNT];
  logic [TAG_W-1:0]  line_tag   [2][SET_COUNT];
  logic [WORD_W-1:0] line_word  [2][SET_COUNT];
  logic              recent_way [SET_COUNT];
  logic [WORD_W-1:0] backing_mem [MEMORY_WORDS];

  cache_response_t expected_responses[$];
  cache_response_t oldest;
  int              mismatches = 0;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic cache_response_t cache_access(input logic op,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [WORD_W-1:0] data);
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    logic             hit0;
    logic             hit1;
    logic             victim;
    cache_response_t  resp;
    set_idx = addr[SET_W-1:0];
    tag     = addr[ADDR_W-1:SET_W];
    hit0    = line_valid[0][set_idx] && (line_tag[0][set_idx] == tag);
    hit1    = !hit0 && line_valid[1][set_idx] && (line_tag[1][set_idx] == tag);
    resp.hit       = hit0 | hit1;
    resp.load_data = '0;
    if (op == OP_STORE) begin
      backing_mem[addr[MEM_IDX_W-1:0]] = data;
      if (hit0 | hit1) begin
        line_word[hit1][set_idx] = data;
        recent_way[set_idx]      = hit1;
      end
    end else if (hit0 | hit1) begin
      resp.load_data      = line_word[hit1][set_idx];
      recent_way[set_idx] = hit1;
    end else begin
      resp.load_data = backing_mem[addr[MEM_IDX_W-1:0]];
      if (!line_valid[0][set_idx]) begin
        victim = 1'b0;
      end else if (!line_valid[1][set_idx]) begin
        victim = 1'b1;
      end else begin
        victim = !recent_way[set_idx];
      end
      line_valid[victim][set_idx] = 1'b1;
      line_tag[victim][set_idx]   = tag;
      line_word[victim][set_idx]  = resp.load_data;
      recent_way[set_idx]         = victim;
    end
    return resp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SET_COUNT; s++) begin
        for (int w = 0; w < 2; w++) begin
          line_valid[w][s] = 1'b0;
          line_tag[w][s]   = '0;
          line_word[w][s]  = '0;
        end
        recent_way[s] = 1'b0;
      end
      for (int a = 0; a < MEMORY_WORDS; a++) begin
        backing_mem[a] = WORD_W'(a + RESET_OFFSET);
      end
      expected_responses.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected result", load_data_i, '0);
        end else begin
          oldest = expected_responses.pop_front();
          if (hit_i !== oldest.hit) begin
            report_mismatch("hit", WORD_W'(hit_i), WORD_W'(oldest.hit));
          end
          if (load_data_i !== oldest.load_data) begin
            report_mismatch("load_data", load_data_i, oldest.load_data);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_responses.push_back(cache_access(operation_i, word_address_i,
                                                  store_data_i));
      end
    end
    pending_o    <= expected_responses.size();
    fail_count_o <= mismatches;
  end

endmodule

// ----- sim/tb_two_way_lru_cache_with_memory_core.sv -----
// Stimulus and verdict for the two-way LRU cache with its backing memory.
`timescale 1ns / 100ps
module tb_two_way_lru_cache_with_memory_core;
  import tlc_pkg::*;

  localparam int RANDOM_ITEMS  = 650;
  localparam int HOLD_CYCLES   = 120;
  localparam int DRAIN_CYCLES  = 20;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic              operation;
  logic [ADDR_W-1:0] word_address;
  logic [WORD_W-1:0] store_data;
  logic              out_valid;
  logic              out_stall;
  logic              hit;
  logic [WORD_W-1:0] load_data;
  int                pending;
  int                fail_count;

  int                burst_left = 0;
  int                hold_requests = 0;
  int                holds_served = 0;
  int                stall_mode = 0;
  int                mode_cycles = 0;
  logic              rand_op;
  logic [ADDR_W-1:0] rand_addr;
  logic [WORD_W-1:0] rand_data;

  always #4 clk_i = ~clk_i;

  two_way_lru_cache_with_memory_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .word_address_i (word_address),
    .store_data_i   (store_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_o          (hit),
    .load_data_o    (load_data)
  );

  cache_response_checker u_response_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .word_address_i (word_address),
    .store_data_i   (store_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .hit_i          (hit),
    .load_data_i    (load_data),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  task automatic offer(input logic op, input logic [ADDR_W-1:0] addr,
                       input logic [WORD_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    word_address <= addr;
    store_data   <= data;
    do @(posedge clk_i); while (in_stall);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (mode_cycles == 0) begin
          stall_mode  = $urandom_range(0, 3);
          mode_cycles = $urandom_range(16, 80);
        end
        mode_cycles--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    operation    <= OP_LOAD;
    word_address <= '0;
    store_data   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Fills of an empty set, hits in both ways, and least recently used eviction.
    offer(OP_LOAD,  7'd0,   32'h0000_0000);
    offer(OP_LOAD,  7'd0,   32'h0000_0000);
    offer(OP_LOAD,  7'd8,   32'h0000_0000);
    offer(OP_LOAD,  7'd0,   32'h0000_0000);
    offer(OP_LOAD,  7'd16,  32'h0000_0000);
    offer(OP_LOAD,  7'd8,   32'h0000_0000);
    offer(OP_LOAD,  7'd16,  32'h0000_0000);
    // Store hits update the line; store misses touch memory only.
    offer(OP_STORE, 7'd16,  32'hFFFF_FFFF);
    offer(OP_LOAD,  7'd16,  32'h0000_0000);
    offer(OP_STORE, 7'd127, 32'hA5A5_A5A5);
    offer(OP_LOAD,  7'd127, 32'h0000_0000);
    offer(OP_STORE, 7'd127, 32'h0000_0000);
    offer(OP_LOAD,  7'd127, 32'h0000_0000);
    offer(OP_STORE, 7'd0,   32'h5A5A_5A5A);
    offer(OP_LOAD,  7'd0,   32'h0000_0000);
    offer(OP_LOAD,  7'd7,   32'hFFFF_FFFF);
    offer(OP_LOAD,  7'd120, 32'hFFFF_FFFF);
    offer(OP_STORE, 7'd120, 32'hFFFF_FFFF);
    offer(OP_LOAD,  7'd120, 32'h0000_0000);
    offer(OP_STORE, 7'd64,  32'h1234_5678);
    offer(OP_STORE, 7'd64,  32'h8765_4321);
    offer(OP_LOAD,  7'd64,  32'h0000_0000);
    offer(OP_LOAD,  7'd56,  32'h0000_0000);
    wait_idle();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) begin
        hold_requests <= hold_requests + 1;
      end
      if (n == 400) begin
        wait_idle();
      end
      rand_op = ($urandom_range(0, 99) < 35) ? OP_STORE : OP_LOAD;
      if ($urandom_range(0, 1) == 0) begin
        rand_addr = {TAG_W'($urandom_range(0, 2)), SET_W'($urandom_range(0, 7))};
      end else begin
        rand_addr = ADDR_W'($urandom_range(0, 127));
      end
      case ($urandom_range(0, 7))
        0: rand_data = '0;
        1: rand_data = '1;
        default: rand_data = $urandom;
      endcase
      offer(rand_op, rand_addr, rand_data);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS two_way_lru_cache_with_memory_core");
    end else begin
      $display("FAIL two_way_lru_cache_with_memory_core");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL two_way_lru_cache_with_memory_core");
    $finish;
  end

endmodule
